### src/msdtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdtq_pkg
// Types, constants and the control store shared by the delay timer queue.
// ----------------------------------------------------------------------------
package msdtq_pkg;

  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TICK_W      = 31;

  localparam logic FUNC_ARM  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic EVENT_EXPIRED  = 1'b0;
  localparam logic EVENT_REJECTED = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  owner_id;
    logic [31:0] delay_us;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] expired_owner;
    logic       last;
  } out_item_t;

  // Sequencer step addresses.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ARM,
    S_TINIT,
    S_READ,
    S_EVAL,
    S_FINISH
  } step_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_ACCEPT,
    C_IS_TICK,
    C_EMPTY,
    C_SCAN_DONE
  } cond_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ARM,
    OP_INIT,
    OP_READ,
    OP_EVAL,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e jump;
    step_e next;
  } uword_t;

  // Control store: one word per step. The jump target is taken when the
  // condition holds, otherwise the sequencer falls through to next.
  function automatic uword_t ucode_rom(input step_e addr);
    uword_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, jump: S_IDLE, next: S_IDLE};
    unique case (addr)
      S_IDLE:     w = '{op: OP_ACCEPT, cond: C_IN_ACCEPT, jump: S_DISPATCH, next: S_IDLE};
      S_DISPATCH: w = '{op: OP_NONE,   cond: C_IS_TICK,   jump: S_TINIT,    next: S_ARM};
      S_ARM:      w = '{op: OP_ARM,    cond: C_ALWAYS,    jump: S_IDLE,     next: S_IDLE};
      S_TINIT:    w = '{op: OP_INIT,   cond: C_EMPTY,     jump: S_IDLE,     next: S_READ};
      S_READ:     w = '{op: OP_READ,   cond: C_ALWAYS,    jump: S_EVAL,     next: S_EVAL};
      S_EVAL:     w = '{op: OP_EVAL,   cond: C_SCAN_DONE, jump: S_FINISH,   next: S_READ};
      S_FINISH:   w = '{op: OP_FLUSH,  cond: C_ALWAYS,    jump: S_IDLE,     next: S_IDLE};
      default:    w = '{op: OP_NONE,   cond: C_ALWAYS,    jump: S_IDLE,     next: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/multi_slot_delay_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_delay_timer_queue_core
// Queue of one-shot delay timers run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one transaction at a time. An arm transaction
// appends an owner and a delay (halved into 2 us ticks) at the queue tail,
// or produces one rejection result when the queue is full. A tick
// transaction counts every entry down and produces one expiry result per
// entry that is due, in queue order, at most eight, the final one marked
// with last. Surviving entries are closed up in order.
// Timing: a tick on a non-empty queue is paced by the single read port of
// the entry memory: each entry needs a read step and an evaluate step.
// in_stall_o is low only while the sequencer waits in its idle step.
// Results sit in an output register; while it is occupied and out_stall_i is
// high the sequencer holds at any step that must emit a further result, and
// resumes when the register is taken. Reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_slot_delay_timer_queue_core
  import msdtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Entry memory.
  logic [TICK_W-1:0] ticks_mem [QUEUE_DEPTH];
  logic [7:0]        owner_mem [QUEUE_DEPTH];
  logic [TICK_W-1:0] rd_ticks_q;
  logic [7:0]        rd_owner_q;

  step_e             step_q, step_d;
  uword_t            uw;
  logic              cond_true;
  logic              hold;
  logic              need_out;

  in_item_t          item_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [RES_W-1:0]  n_q, n_d;
  logic              pend_q, pend_d;
  logic [7:0]        pend_owner_q, pend_owner_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_busy;
  logic              ld_out;

  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [TICK_W-1:0] wr_ticks;
  logic [7:0]        wr_owner;

  logic              full;
  logic              expire;
  logic              accept;

  assign in_stall_o  = (step_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign expire   = (rd_ticks_q <= TICK_W'(1)) && (n_q != RES_W'(MAX_RESULTS));

  always_comb begin
    uw = ucode_rom(step_q);

    case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_IN_ACCEPT: cond_true = accept;
      C_IS_TICK:   cond_true = (item_q.func == FUNC_TICK);
      C_EMPTY:     cond_true = (count_q == '0);
      C_SCAN_DONE: cond_true = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
      default:     cond_true = 1'b1;
    endcase

    // Steps that emit a result must wait for the output register to free up.
    need_out = 1'b0;
    case (uw.op)
      OP_ARM:   need_out = full;
      OP_EVAL:  need_out = expire && pend_q;
      OP_FLUSH: need_out = pend_q;
      default:  need_out = 1'b0;
    endcase
    hold = need_out && out_busy;

    step_d       = hold ? step_q : (cond_true ? uw.jump : uw.next);
    count_d      = count_q;
    idx_d        = idx_q;
    kept_d       = kept_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_owner_d = pend_owner_q;
    ld_out       = 1'b0;
    out_d        = out_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = count_q[IDX_W-1:0];
    wr_ticks     = item_q.delay_us[31:1];
    wr_owner     = item_q.owner_id;

    if (!hold) begin
      unique case (uw.op)
        OP_NONE, OP_ACCEPT, OP_READ: ;
        OP_ARM: begin
          if (full) begin
            ld_out = 1'b1;
            out_d  = '{event_kind: EVENT_REJECTED, expired_owner: item_q.owner_id,
                       last: 1'b1};
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_INIT: begin
          idx_d  = '0;
          kept_d = '0;
          n_d    = '0;
          pend_d = 1'b0;
        end
        OP_EVAL: begin
          idx_d = idx_q + IDX_W'(1);
          if (expire) begin
            // The previous expiry is now known not to be the final one.
            if (pend_q) begin
              ld_out = 1'b1;
              out_d  = '{event_kind: EVENT_EXPIRED, expired_owner: pend_owner_q,
                         last: 1'b0};
            end
            pend_d       = 1'b1;
            pend_owner_d = rd_owner_q;
            n_d          = n_q + RES_W'(1);
          end else begin
            wr_en    = 1'b1;
            wr_addr  = kept_q[IDX_W-1:0];
            wr_ticks = (rd_ticks_q == '0) ? '0 : (rd_ticks_q - TICK_W'(1));
            wr_owner = rd_owner_q;
            kept_d   = kept_q + CNT_W'(1);
          end
        end
        OP_FLUSH: begin
          if (pend_q) begin
            ld_out = 1'b1;
            out_d  = '{event_kind: EVENT_EXPIRED, expired_owner: pend_owner_q,
                       last: 1'b1};
          end
          pend_d  = 1'b0;
          count_d = kept_q;
        end
        default: ;
      endcase
    end
    if (uw.op == OP_READ) begin
      rd_en = 1'b1;
    end

    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_owner_q <= pend_owner_d;
    out_q        <= out_d;
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ticks_mem[wr_addr] <= wr_ticks;
      owner_mem[wr_addr] <= wr_owner;
    end
    if (rd_en) begin
      rd_ticks_q <= ticks_mem[idx_q];
      rd_owner_q <= owner_mem[idx_q];
    end
  end

endmodule
